// ----- src/pit3d_pkg.sv -----
// Shared constants and width helpers for the 3D point-in-triangle pipeline.
`default_nettype none

package pit3d_pkg;

    localparam int COORD_BITS_DEF = 16;
    localparam int NUM_AXES       = 3;
    localparam int NUM_EDGES      = 3;

    // cyclic successor / predecessor of a vertex or axis index
    localparam int NEXT_IDX [3] = '{1, 2, 0};
    localparam int PREV_IDX [3] = '{2, 0, 1};

    // coordinate differences carry one extra bit
    function automatic int diff_bits(input int coord_bits);
        return coord_bits + 1;
    endfunction

    // cross product of two differences: two products and a subtract
    function automatic int cross_bits(input int coord_bits);
        return 2 * coord_bits + 3;
    endfunction

endpackage

`default_nettype wire

// ----- src/pit3d_diff.sv -----
// Stage 1: edge vectors and vertex-to-query vectors.
`default_nettype none

module pit3d_diff
    import pit3d_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
)
(
    input  logic                                         clk,
    input  logic                                         rst_n,
    input  logic                                         in_valid,
    input  logic signed [COORD_BITS-1:0]                 vert   [NUM_EDGES][NUM_AXES],
    input  logic signed [COORD_BITS-1:0]                 query  [NUM_AXES],
    output logic                                         out_valid,
    output logic signed [diff_bits(COORD_BITS)-1:0]      edge_v [NUM_EDGES][NUM_AXES],
    output logic signed [diff_bits(COORD_BITS)-1:0]      rel_v  [NUM_EDGES][NUM_AXES]
);

    localparam int D = diff_bits(COORD_BITS);

    logic                valid_reg;
    logic signed [D-1:0] edge_reg  [NUM_EDGES][NUM_AXES];
    logic signed [D-1:0] rel_reg   [NUM_EDGES][NUM_AXES];
    logic signed [D-1:0] edge_next [NUM_EDGES][NUM_AXES];
    logic signed [D-1:0] rel_next  [NUM_EDGES][NUM_AXES];

    always_comb
    begin
        for (int k = 0; k < NUM_EDGES; k++)
        begin
            for (int c = 0; c < NUM_AXES; c++)
            begin
                // edge k runs from vertex k to the next vertex
                edge_next[k][c] = D'(vert[NEXT_IDX[k]][c]) - D'(vert[k][c]);
                rel_next[k][c]  = D'(query[c]) - D'(vert[k][c]);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        edge_reg <= edge_next;
        rel_reg  <= rel_next;
    end

    assign out_valid = valid_reg;
    assign edge_v    = edge_reg;
    assign rel_v     = rel_reg;

endmodule

`default_nettype wire

// ----- src/pit3d_cross.sv -----
// Stages 2-3: per-edge test normals and the triangle plane normal.
`default_nettype none

module pit3d_cross
    import pit3d_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
)
(
    input  logic                                         clk,
    input  logic                                         rst_n,
    input  logic                                         in_valid,
    input  logic signed [diff_bits(COORD_BITS)-1:0]      edge_v  [NUM_EDGES][NUM_AXES],
    input  logic signed [diff_bits(COORD_BITS)-1:0]      rel_v   [NUM_EDGES][NUM_AXES],
    output logic                                         out_valid,
    output logic signed [cross_bits(COORD_BITS)-1:0]     edge_n  [NUM_EDGES][NUM_AXES],
    output logic signed [cross_bits(COORD_BITS)-1:0]     plane_n [NUM_AXES]
);

    localparam int D      = diff_bits(COORD_BITS);
    localparam int M      = 2 * D;
    localparam int C      = cross_bits(COORD_BITS);
    localparam int NCROSS = NUM_EDGES + 1;

    // Since the edges sum to zero, u1 x u3, u2 x u1 and u3 x u2 are all
    // equal, so one plane normal (u2 x u1) serves every edge test.
    logic signed [D-1:0] op_a [NCROSS][NUM_AXES];
    logic signed [D-1:0] op_b [NCROSS][NUM_AXES];

    logic                valid_p_reg;
    logic                valid_c_reg;
    logic signed [M-1:0] pos_reg   [NCROSS][NUM_AXES];
    logic signed [M-1:0] neg_reg   [NCROSS][NUM_AXES];
    logic signed [M-1:0] pos_next  [NCROSS][NUM_AXES];
    logic signed [M-1:0] neg_next  [NCROSS][NUM_AXES];
    logic signed [C-1:0] cross_reg  [NCROSS][NUM_AXES];
    logic signed [C-1:0] cross_next [NCROSS][NUM_AXES];

    always_comb
    begin
        for (int k = 0; k < NUM_EDGES; k++)
        begin
            op_a[k] = rel_v[k];
            op_b[k] = edge_v[k];
        end
        op_a[NUM_EDGES] = edge_v[1];
        op_b[NUM_EDGES] = edge_v[0];
    end

    always_comb
    begin
        for (int k = 0; k < NCROSS; k++)
        begin
            for (int c = 0; c < NUM_AXES; c++)
            begin
                pos_next[k][c] = op_a[k][NEXT_IDX[c]] * op_b[k][PREV_IDX[c]];
                neg_next[k][c] = op_a[k][PREV_IDX[c]] * op_b[k][NEXT_IDX[c]];
            end
        end
    end

    always_comb
    begin
        for (int k = 0; k < NCROSS; k++)
        begin
            for (int c = 0; c < NUM_AXES; c++)
            begin
                cross_next[k][c] = C'(pos_reg[k][c]) - C'(neg_reg[k][c]);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_p_reg <= 1'b0;
            valid_c_reg <= 1'b0;
        end
        else
        begin
            valid_p_reg <= in_valid;
            valid_c_reg <= valid_p_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg   <= pos_next;
        neg_reg   <= neg_next;
        cross_reg <= cross_next;
    end

    always_comb
    begin
        for (int k = 0; k < NUM_EDGES; k++)
        begin
            edge_n[k] = cross_reg[k];
        end
        plane_n = cross_reg[NUM_EDGES];
    end

    assign out_valid = valid_c_reg;

endmodule

`default_nettype wire

// ----- src/pit3d_dot.sv -----
// Stages 4-6: split dot products of edge normals with the plane normal, sign test.
`default_nettype none

module pit3d_dot
    import pit3d_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
)
(
    input  logic                                         clk,
    input  logic                                         rst_n,
    input  logic                                         in_valid,
    input  logic signed [cross_bits(COORD_BITS)-1:0]     edge_n  [NUM_EDGES][NUM_AXES],
    input  logic signed [cross_bits(COORD_BITS)-1:0]     plane_n [NUM_AXES],
    output logic                                         out_valid,
    output logic [NUM_EDGES-1:0]                         edge_neg
);

    localparam int W = cross_bits(COORD_BITS);
    localparam int L = (W + 1) / 2;     // low slice, unsigned
    localparam int H = W - L;           // high slice, signed
    localparam int P = 2 * W;           // exact product width
    localparam int S = P + 2;           // sum of three products

    logic                    valid_a_reg;
    logic                    valid_b_reg;
    logic                    valid_c_reg;

    logic        [2*L-1:0]   ll_reg   [NUM_EDGES][NUM_AXES];
    logic signed [L+H:0]     lh_reg   [NUM_EDGES][NUM_AXES];
    logic signed [L+H:0]     hl_reg   [NUM_EDGES][NUM_AXES];
    logic signed [2*H-1:0]   hh_reg   [NUM_EDGES][NUM_AXES];
    logic        [2*L-1:0]   ll_next  [NUM_EDGES][NUM_AXES];
    logic signed [L+H:0]     lh_next  [NUM_EDGES][NUM_AXES];
    logic signed [L+H:0]     hl_next  [NUM_EDGES][NUM_AXES];
    logic signed [2*H-1:0]   hh_next  [NUM_EDGES][NUM_AXES];

    logic signed [P-1:0]     prod_reg  [NUM_EDGES][NUM_AXES];
    logic signed [P-1:0]     prod_next [NUM_EDGES][NUM_AXES];

    logic signed [S-1:0]     sum_next  [NUM_EDGES];
    logic [NUM_EDGES-1:0]    neg_reg;
    logic [NUM_EDGES-1:0]    neg_next;

    // partial products of the split operands
    always_comb
    begin
        for (int e = 0; e < NUM_EDGES; e++)
        begin
            for (int c = 0; c < NUM_AXES; c++)
            begin
                ll_next[e][c] = edge_n[e][c][L-1:0] * plane_n[c][L-1:0];
                lh_next[e][c] = $signed({1'b0, edge_n[e][c][L-1:0]})
                              * $signed(plane_n[c][W-1:L]);
                hl_next[e][c] = $signed(edge_n[e][c][W-1:L])
                              * $signed({1'b0, plane_n[c][L-1:0]});
                hh_next[e][c] = $signed(edge_n[e][c][W-1:L])
                              * $signed(plane_n[c][W-1:L]);
            end
        end
    end

    // recombine into exact products
    always_comb
    begin
        for (int e = 0; e < NUM_EDGES; e++)
        begin
            for (int c = 0; c < NUM_AXES; c++)
            begin
                prod_next[e][c] = P'($signed({1'b0, ll_reg[e][c]}))
                                + (P'(lh_reg[e][c]) <<< L)
                                + (P'(hl_reg[e][c]) <<< L)
                                + (P'(hh_reg[e][c]) <<< (2 * L));
            end
        end
    end

    always_comb
    begin
        for (int e = 0; e < NUM_EDGES; e++)
        begin
            sum_next[e] = S'(prod_reg[e][0]) + S'(prod_reg[e][1]) + S'(prod_reg[e][2]);
            neg_next[e] = sum_next[e][S-1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_a_reg <= 1'b0;
            valid_b_reg <= 1'b0;
            valid_c_reg <= 1'b0;
        end
        else
        begin
            valid_a_reg <= in_valid;
            valid_b_reg <= valid_a_reg;
            valid_c_reg <= valid_b_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        ll_reg   <= ll_next;
        lh_reg   <= lh_next;
        hl_reg   <= hl_next;
        hh_reg   <= hh_next;
        prod_reg <= prod_next;
        neg_reg  <= neg_next;
    end

    assign out_valid = valid_c_reg;
    assign edge_neg  = neg_reg;

endmodule

`default_nettype wire

// ----- src/point_in_triangle_3d.sv -----
// Top level: pipelined exact inside test of a point against a 3D triangle.
//
// Usage: drive the three vertices a, b, c and the query point with start high;
// a request is taken on every rising edge where start is high and busy is low.
// busy is held low, so a new request can be taken on every clock.
// Each request yields exactly one result: done is high for one cycle with
// inside_res valid, 1 when no edge test comes out negative.
// The request passes through seven register stages: differences, cross
// products, cross subtract, split dot partials, product recombine, dot sum
// and sign, output. Throughput: one request per clock, sustained.
// The depth is set by the exact wide dot products, which are split into
// half-width partial products and recombined in a following stage.
// Results leave in request order. The receiver cannot stall, and the
// pipeline never needs it to.
// Reset (rst_n low, asynchronous) clears all valid bits, so no done strobe
// appears until a request has gone through; data registers are not reset.
`default_nettype none

module point_in_triangle_3d
    import pit3d_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic signed [COORD_BITS-1:0] a_x,
    input  logic signed [COORD_BITS-1:0] a_y,
    input  logic signed [COORD_BITS-1:0] a_z,
    input  logic signed [COORD_BITS-1:0] b_x,
    input  logic signed [COORD_BITS-1:0] b_y,
    input  logic signed [COORD_BITS-1:0] b_z,
    input  logic signed [COORD_BITS-1:0] c_x,
    input  logic signed [COORD_BITS-1:0] c_y,
    input  logic signed [COORD_BITS-1:0] c_z,
    input  logic signed [COORD_BITS-1:0] query_x,
    input  logic signed [COORD_BITS-1:0] query_y,
    input  logic signed [COORD_BITS-1:0] query_z,
    output logic                         done,
    output logic                         inside_res
);

    localparam int D = diff_bits(COORD_BITS);
    localparam int C = cross_bits(COORD_BITS);

    logic signed [COORD_BITS-1:0] vert  [NUM_EDGES][NUM_AXES];
    logic signed [COORD_BITS-1:0] query [NUM_AXES];

    logic                diff_valid;
    logic signed [D-1:0] edge_v [NUM_EDGES][NUM_AXES];
    logic signed [D-1:0] rel_v  [NUM_EDGES][NUM_AXES];

    logic                cross_valid;
    logic signed [C-1:0] edge_n  [NUM_EDGES][NUM_AXES];
    logic signed [C-1:0] plane_n [NUM_AXES];

    logic                 dot_valid;
    logic [NUM_EDGES-1:0] edge_neg;

    logic done_reg;
    logic inside_reg;
    logic inside_next;

    assign busy = 1'b0;

    assign vert[0] = '{a_x, a_y, a_z};
    assign vert[1] = '{b_x, b_y, b_z};
    assign vert[2] = '{c_x, c_y, c_z};
    assign query   = '{query_x, query_y, query_z};

    pit3d_diff #(
        .COORD_BITS (COORD_BITS)
    ) u_diff (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (start & ~busy),
        .vert      (vert),
        .query     (query),
        .out_valid (diff_valid),
        .edge_v    (edge_v),
        .rel_v     (rel_v)
    );

    pit3d_cross #(
        .COORD_BITS (COORD_BITS)
    ) u_cross (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (diff_valid),
        .edge_v    (edge_v),
        .rel_v     (rel_v),
        .out_valid (cross_valid),
        .edge_n    (edge_n),
        .plane_n   (plane_n)
    );

    pit3d_dot #(
        .COORD_BITS (COORD_BITS)
    ) u_dot (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (cross_valid),
        .edge_n    (edge_n),
        .plane_n   (plane_n),
        .out_valid (dot_valid),
        .edge_neg  (edge_neg)
    );

    // zero dot products count as inside
    assign inside_next = ~(|edge_neg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= dot_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        inside_reg <= inside_next;
    end

    assign done       = done_reg;
    assign inside_res = inside_reg;

endmodule

`default_nettype wire

// ----- tb/sv/tb_point_in_triangle_3d.sv -----
// Testbench for point_in_triangle_3d: directed and random requests checked against a predictor.
`default_nettype none

module tb_point_in_triangle_3d
    import pit3d_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CB = COORD_BITS_DEF;
    localparam longint COORD_MIN = -(longint'(1) <<< (CB - 1));
    localparam longint COORD_MAX = (longint'(1) <<< (CB - 1)) - 1;

    typedef logic signed [CB-1:0] coord_t;
    typedef struct packed {
        coord_t x;
        coord_t y;
        coord_t z;
    } pt_t;
    typedef struct {
        longint x;
        longint y;
        longint z;
    } vec_t;
    typedef logic signed [127:0] wide_t;

    logic   clk = 1'b0;
    logic   rst_n = 1'b0;
    logic   start = 1'b0;
    logic   busy;
    coord_t a_x = '0, a_y = '0, a_z = '0;
    coord_t b_x = '0, b_y = '0, b_z = '0;
    coord_t c_x = '0, c_y = '0, c_z = '0;
    coord_t query_x = '0, query_y = '0, query_z = '0;
    logic   done;
    logic   inside_res;

    bit     inside_q[$];
    int     err_cnt = 0;
    int     burst_left = 0;

    point_in_triangle_3d #(.COORD_BITS(CB)) u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .a_x        (a_x),
        .a_y        (a_y),
        .a_z        (a_z),
        .b_x        (b_x),
        .b_y        (b_y),
        .b_z        (b_z),
        .c_x        (c_x),
        .c_y        (c_y),
        .c_z        (c_z),
        .query_x    (query_x),
        .query_y    (query_y),
        .query_z    (query_z),
        .done       (done),
        .inside_res (inside_res)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    // ---------------- predictor ----------------

    function automatic vec_t to_vec(pt_t p);
        vec_t v;
        v.x = longint'(p.x);
        v.y = longint'(p.y);
        v.z = longint'(p.z);
        return v;
    endfunction

    function automatic vec_t vec_diff(vec_t p, vec_t q);
        vec_t r;
        r.x = p.x - q.x;
        r.y = p.y - q.y;
        r.z = p.z - q.z;
        return r;
    endfunction

    function automatic vec_t cross_prod(vec_t u, vec_t v);
        vec_t r;
        r.x = u.y * v.z - u.z * v.y;
        r.y = u.z * v.x - u.x * v.z;
        r.z = u.x * v.y - u.y * v.x;
        return r;
    endfunction

    // cross components reach ~2^33, so the dot needs more than 64 bits
    function automatic bit dot_negative(vec_t u, vec_t v);
        wide_t acc;
        acc = wide_t'(u.x) * wide_t'(v.x) + wide_t'(u.y) * wide_t'(v.y)
            + wide_t'(u.z) * wide_t'(v.z);
        return acc < 0;
    endfunction

    function automatic bit side_fails(vec_t q, vec_t s, vec_t e, vec_t o);
        return dot_negative(cross_prod(vec_diff(q, s), e), cross_prod(e, o));
    endfunction

    function automatic bit predict_inside(pt_t pa, pt_t pb, pt_t pc, pt_t pq);
        vec_t va, vb, vc, vq, u1, u2, u3;
        va = to_vec(pa);
        vb = to_vec(pb);
        vc = to_vec(pc);
        vq = to_vec(pq);
        u1 = vec_diff(vb, va);
        u2 = vec_diff(vc, vb);
        u3 = vec_diff(va, vc);
        return !(side_fails(vq, va, u1, u3) || side_fails(vq, vb, u2, u1)
                 || side_fails(vq, vc, u3, u2));
    endfunction

    // ---------------- result checking ----------------

    always @(posedge clk)
    begin
        bit exp_in;
        if (start && !busy)
            inside_q.push_back(predict_inside({a_x, a_y, a_z}, {b_x, b_y, b_z},
                                              {c_x, c_y, c_z},
                                              {query_x, query_y, query_z}));
        if (done === 1'b1)
        begin
            if (inside_q.size() == 0)
            begin
                $error("done strobe with no request outstanding");
                err_cnt++;
            end
            else
            begin
                exp_in = inside_q.pop_front();
                if (inside_res !== exp_in)
                begin
                    $error("inside_res: expected %0d, got %b", exp_in, inside_res);
                    err_cnt++;
                end
            end
        end
    end

    // ---------------- stimulus helpers ----------------

    function automatic pt_t mk(longint x, longint y, longint z);
        pt_t p;
        p.x = coord_t'(x);
        p.y = coord_t'(y);
        p.z = coord_t'(z);
        return p;
    endfunction

    function automatic longint clamp_coord(longint v);
        if (v < COORD_MIN)
            return COORD_MIN;
        if (v > COORD_MAX)
            return COORD_MAX;
        return v;
    endfunction

    function automatic longint rnd_coord(int mode);
        case (mode)
            0: return longint'(coord_t'($urandom));
            1: return longint'($urandom_range(0, 16)) - 8;
            2: return longint'($urandom_range(0, 2000)) - 1000;
            default:
            begin
                case ($urandom_range(0, 5))
                    0: return COORD_MIN;
                    1: return COORD_MAX;
                    2: return 0;
                    3: return -1;
                    4: return 1;
                    default: return longint'(coord_t'($urandom));
                endcase
            end
        endcase
    endfunction

    function automatic pt_t rnd_pt(int mode);
        return mk(rnd_coord(mode), rnd_coord(mode), rnd_coord(mode));
    endfunction

    // weighted mix of the vertices, nudged a little: lands near the triangle
    function automatic pt_t near_pt(pt_t pa, pt_t pb, pt_t pc);
        longint w0, w1, w2, ws, nz;
        vec_t   va, vb, vc, r;
        w0 = $urandom_range(0, 7);
        w1 = $urandom_range(0, 7);
        w2 = $urandom_range(0, 7);
        if (w0 + w1 + w2 == 0)
            w0 = 1;
        ws = w0 + w1 + w2;
        nz = ($urandom_range(0, 2) == 0) ? 0 : 2;
        va = to_vec(pa);
        vb = to_vec(pb);
        vc = to_vec(pc);
        r.x = (w0 * va.x + w1 * vb.x + w2 * vc.x) / ws + longint'($urandom_range(0, 2 * nz)) - nz;
        r.y = (w0 * va.y + w1 * vb.y + w2 * vc.y) / ws + longint'($urandom_range(0, 2 * nz)) - nz;
        r.z = (w0 * va.z + w1 * vb.z + w2 * vc.z) / ws + longint'($urandom_range(0, 2 * nz)) - nz;
        return mk(clamp_coord(r.x), clamp_coord(r.y), clamp_coord(r.z));
    endfunction

    task automatic send_req(pt_t pa, pt_t pb, pt_t pc, pt_t pq);
        start   <= 1'b1;
        a_x     <= pa.x;
        a_y     <= pa.y;
        a_z     <= pa.z;
        b_x     <= pb.x;
        b_y     <= pb.y;
        b_z     <= pb.z;
        c_x     <= pc.x;
        c_y     <= pc.y;
        c_z     <= pc.z;
        query_x <= pq.x;
        query_y <= pq.y;
        query_z <= pq.z;
        do
            @(posedge clk);
        while (busy !== 1'b0);
    endtask

    task automatic idle(int n);
        start <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    // one edge first, so the last request is already in the queue
    task automatic wait_drained();
        start <= 1'b0;
        @(posedge clk);
        while (inside_q.size() != 0)
            @(posedge clk);
    endtask

    // bursts of random length; a quarter of them follow with no gap at all
    task automatic pace();
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            if ($urandom_range(0, 3) != 0)
                idle($urandom_range(1, 7));
        end
        burst_left--;
    endtask

    task automatic send_random();
        pt_t pa, pb, pc, pq;
        int  sel, vm;
        sel = $urandom_range(0, 99);
        if (sel < 40)
        begin
            vm = ($urandom_range(0, 1) == 0) ? 0 : 2;
            pa = rnd_pt(vm);
            pb = rnd_pt(vm);
            pc = rnd_pt(vm);
            pq = near_pt(pa, pb, pc);
        end
        else
        begin
            vm = (sel < 60) ? 1 : (sel < 85) ? 0 : 3;
            pa = rnd_pt(vm);
            pb = rnd_pt(vm);
            pc = rnd_pt(vm);
            pq = rnd_pt(vm);
        end
        send_req(pa, pb, pc, pq);
    endtask

    // ---------------- tests ----------------

    task automatic test_vertices_and_sides();
        pt_t pa, pb, pc;
        pa = mk(0, 0, 0);
        pb = mk(100, 0, 0);
        pc = mk(0, 100, 0);
        send_req(pa, pb, pc, pa);
        send_req(pa, pb, pc, pb);
        send_req(pa, pb, pc, pc);
        send_req(pa, pb, pc, mk(50, 0, 0));
        send_req(pa, pb, pc, mk(50, 50, 0));
        send_req(pa, pb, pc, mk(0, 37, 0));
        send_req(pa, pb, pc, mk(51, 50, 0));
        send_req(pa, pb, pc, mk(-1, 10, 0));
        send_req(pa, pb, pc, mk(20, 20, 0));
    endtask

    task automatic test_degenerate();
        send_req(mk(0, 0, 0), mk(10, 10, 10), mk(30, 30, 30), mk(20, 20, 20));
        send_req(mk(0, 0, 0), mk(10, 10, 10), mk(30, 30, 30), mk(-500, 700, 3));
        send_req(mk(5, -5, 7), mk(5, -5, 7), mk(5, -5, 7), mk(1000, 2000, -3000));
        send_req(mk(1, 2, 3), mk(1, 2, 3), mk(40, -9, 8), mk(-40, 9, -8));
    endtask

    task automatic test_off_plane();
        pt_t pa, pb, pc;
        pa = mk(-1000, -1000, 0);
        pb = mk(1000, -1000, 0);
        pc = mk(0, 1000, 0);
        send_req(pa, pb, pc, mk(0, 0, COORD_MAX));
        send_req(pa, pb, pc, mk(0, 2000, COORD_MIN));
    endtask

    task automatic test_extremes();
        pt_t lo, hi;
        lo = mk(COORD_MIN, COORD_MIN, COORD_MIN);
        hi = mk(COORD_MAX, COORD_MAX, COORD_MAX);
        send_req(lo, lo, lo, lo);
        send_req(hi, hi, hi, hi);
        send_req(mk(COORD_MIN, COORD_MIN, COORD_MIN), mk(COORD_MAX, COORD_MIN, COORD_MAX),
                 mk(COORD_MIN, COORD_MAX, COORD_MAX), mk(COORD_MAX, COORD_MAX, COORD_MIN));
        send_req(mk(COORD_MIN, COORD_MIN, COORD_MIN), mk(COORD_MAX, COORD_MIN, COORD_MAX),
                 mk(COORD_MIN, COORD_MAX, COORD_MAX), mk(COORD_MIN, 0, COORD_MAX));
        send_req(mk(COORD_MAX, COORD_MIN, 0), mk(COORD_MIN, COORD_MAX, 0),
                 mk(COORD_MIN, COORD_MIN, 0), mk(COORD_MIN + 1, COORD_MIN + 1, 0));
        send_req(mk(16'sh5555, 16'shAAAA, 16'sh5555), mk(16'shAAAA, 16'sh5555, 16'shAAAA),
                 mk(16'sh5555, 16'sh5555, 16'shAAAA), mk(16'shAAAA, 16'shAAAA, 16'sh5555));
    endtask

    task automatic test_random_bursts(int n);
        repeat (n)
        begin
            pace();
            send_random();
        end
    endtask

    // pipeline runs empty between groups; start is already low after the drain
    task automatic test_drain_pause(int groups);
        repeat (groups)
        begin
            repeat ($urandom_range(1, 12)) send_random();
            wait_drained();
            repeat ($urandom_range(0, 3)) @(posedge clk);
        end
    endtask

    task automatic test_back_to_back(int n);
        repeat (n) send_random();
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_vertices_and_sides();
        test_degenerate();
        test_off_plane();
        test_extremes();
        test_random_bursts(300);
        test_drain_pause(8);
        test_back_to_back(240);
        wait_drained();
        repeat (12) @(posedge clk);
        if (err_cnt == 0 && inside_q.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule

`default_nettype wire
